// ----- src/r0s_pkg.sv -----
// Package for the RAID-0 request splitter: widths, register indexes, command/status structs.
// No dependencies.
package r0s_pkg;
  localparam int MAX_DEVICES = 16;
  localparam int OFF_W = 47;
  localparam int LEN_W = 40;
  localparam int POS_W = 48;
  localparam int DOFF_W = 48;
  localparam int DIDX_W = 4;
  localparam int CNT_W = 5;
  localparam int CHUNK_W = 32;
  localparam int WID_W = 36;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = 1'd1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic div_sel_end;
    logic div_latch;
    logic first_dev;
    logic emit;
    logic next_dev;
  } r0s_cmd_t;

  typedef struct packed {
    logic div_done;
    logic len_zero;
    logic left_zero;
    logic at_last_visit;
  } r0s_sts_t;
endpackage

// ----- src/raid0_request_splitter.sv -----
// Top level of the RAID-0 request splitter: config registers, controller and datapath.
// Depends on r0s_pkg, r0s_control, r0s_datapath.
//
// channel | dir | tdata                          | tuser
// in_     | in  | request_offset, request_length | -
// out_    | out | device_index, offset, length   | - (tlast = last)
// cfg_    | in  | device_count, chunk_size       | -
//
// A request runs the offset, then the end position, through the shared restoring divider (one
// quotient bit per cycle over the stripe width), then picks the first member and emits the
// sub-requests member by member. Zero length gives no sub-request.
// Reset is synchronous, active low; out_tvalid clears. An output stall holds the
// sequencer at the next sub-request; the input is taken only when idle.
module raid0_request_splitter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [87:0]                       in_tdata,   // request_offset[46:0], request_length[86:47]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [95:0]                       out_tdata,  // device_index[3:0], offset[51:4], length[91:52]
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [r0s_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [r0s_pkg::CHUNK_W-1:0]       cfg_wdata
);
  logic [r0s_pkg::CNT_W-1:0]   devcnt_r;
  logic [r0s_pkg::CHUNK_W-1:0] chunk_r;
  logic [r0s_pkg::CNT_W-1:0]   ndev;
  logic [r0s_pkg::CHUNK_W-1:0] chunk;
  r0s_pkg::r0s_cmd_t cmd;
  r0s_pkg::r0s_sts_t sts;
  logic busy, in_fire, out_fire;
  logic [r0s_pkg::DIDX_W-1:0] o_dev;
  logic [r0s_pkg::DOFF_W-1:0] o_off;
  logic [r0s_pkg::LEN_W-1:0]  o_len;

  assign ndev = (devcnt_r == '0) ? r0s_pkg::CNT_W'(1) :
                (devcnt_r > r0s_pkg::CNT_W'(r0s_pkg::MAX_DEVICES)) ?
                r0s_pkg::CNT_W'(r0s_pkg::MAX_DEVICES) : devcnt_r;
  assign chunk = (chunk_r == '0) ? r0s_pkg::CHUNK_W'(1) : chunk_r;
  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign out_tdata = {4'b0, o_len, o_off, o_dev};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      devcnt_r <= r0s_pkg::CNT_W'(2);
      chunk_r <= r0s_pkg::CHUNK_W'(4194304);
    end else if (cfg_we) begin
      case (cfg_index)
        r0s_pkg::REG_DEVICE_COUNT: devcnt_r <= cfg_wdata[r0s_pkg::CNT_W-1:0];
        r0s_pkg::REG_CHUNK_SIZE:   chunk_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  r0s_control u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_tvalid)
  );

  r0s_datapath u_dp (
    .clk(clk), .req_off(in_tdata[46:0]), .req_len(in_tdata[86:47]),
    .ndev(ndev), .chunk(chunk), .cmd(cmd), .sts(sts),
    .o_dev(o_dev), .o_off(o_off), .o_len(o_len), .o_last(out_tlast)
  );
endmodule

// ----- src/r0s_datapath.sv -----
// Datapath: restoring divider over the stripe width, member mapping and output register.
// Depends on r0s_pkg.
module r0s_datapath (
  input  logic                          clk,
  input  logic [r0s_pkg::OFF_W-1:0]     req_off,
  input  logic [r0s_pkg::LEN_W-1:0]     req_len,
  input  logic [r0s_pkg::CNT_W-1:0]     ndev,
  input  logic [r0s_pkg::CHUNK_W-1:0]   chunk,
  input  r0s_pkg::r0s_cmd_t             cmd,
  output r0s_pkg::r0s_sts_t             sts,
  output logic [r0s_pkg::DIDX_W-1:0]    o_dev,
  output logic [r0s_pkg::DOFF_W-1:0]    o_off,
  output logic [r0s_pkg::LEN_W-1:0]     o_len,
  output logic                          o_last
);
  localparam int STEP_W = $clog2(r0s_pkg::POS_W + 1);

  logic [r0s_pkg::POS_W-1:0]   off_r, end_r, dvd_r;
  logic [r0s_pkg::DOFF_W-1:0]  qc_r;
  logic [r0s_pkg::WID_W:0]     rem_r;
  logic [STEP_W-1:0]           step_r;
  logic [r0s_pkg::WID_W-1:0]   width_r, ws_r, we_r, base_r;
  logic [r0s_pkg::DOFF_W-1:0]  sbs_r, sbe_r;
  logic [r0s_pkg::LEN_W-1:0]   left_r;
  logic [r0s_pkg::DIDX_W-1:0]  dev_r;
  logic [r0s_pkg::CNT_W-1:0]   vis_r;
  logic [r0s_pkg::DIDX_W:0]    fdev;
  logic [r0s_pkg::WID_W:0]     trial;
  logic [r0s_pkg::WID_W:0]     rsh;
  logic [r0s_pkg::CHUNK_W:0]   ps, pe;
  logic [r0s_pkg::DOFF_W-1:0]  ds, de;
  logic [r0s_pkg::LEN_W-1:0]   dl;

  // Part of a within-stripe position falling on the current member, clamped.
  function automatic logic [r0s_pkg::CHUNK_W:0] clamp_part(
    input logic [r0s_pkg::WID_W-1:0] w, input logic [r0s_pkg::WID_W-1:0] b,
    input logic [r0s_pkg::CHUNK_W-1:0] c);
    logic [r0s_pkg::WID_W-1:0] d;
    d = w - b;
    if (w < b) clamp_part = '0;
    else if (d > {{(r0s_pkg::WID_W-r0s_pkg::CHUNK_W){1'b0}}, c}) clamp_part = {1'b0, c};
    else clamp_part = d[r0s_pkg::CHUNK_W:0];
  endfunction

  assign rsh = {rem_r[r0s_pkg::WID_W-1:0], dvd_r[r0s_pkg::POS_W-1]};
  assign trial = rsh - {1'b0, width_r};
  assign ps = clamp_part(ws_r, base_r, chunk);
  assign pe = clamp_part(we_r, base_r, chunk);
  assign ds = sbs_r + {{(r0s_pkg::DOFF_W-r0s_pkg::CHUNK_W-1){1'b0}}, ps};
  assign de = sbe_r + {{(r0s_pkg::DOFF_W-r0s_pkg::CHUNK_W-1){1'b0}}, pe};
  assign dl = (de >= ds) ? r0s_pkg::LEN_W'(de - ds) : '0;

  // First member: compare the within-stripe offset against each chunk multiple.
  always_comb begin
    fdev = '0;
    for (int k = 1; k < r0s_pkg::MAX_DEVICES; k++) begin
      if (ws_r >= r0s_pkg::WID_W'(k) * r0s_pkg::WID_W'(chunk))
        fdev = (r0s_pkg::DIDX_W+1)'(k);
    end
  end

  assign sts.div_done = (step_r == '0);
  assign sts.len_zero = (req_len == '0);
  assign sts.left_zero = (left_r == '0);
  assign sts.at_last_visit = (vis_r == ndev);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_r <= {1'b0, req_off};
      end_r <= {1'b0, req_off} + {{(r0s_pkg::POS_W-r0s_pkg::LEN_W){1'b0}}, req_len};
      left_r <= req_len;
      width_r <= r0s_pkg::WID_W'(ndev) * r0s_pkg::WID_W'(chunk);
    end
    if (cmd.div_start) begin
      dvd_r <= cmd.div_sel_end ? end_r : off_r;
      rem_r <= '0;
      qc_r <= '0;
      step_r <= STEP_W'(r0s_pkg::POS_W);
    end else if (cmd.div_step) begin
      if (!trial[r0s_pkg::WID_W]) rem_r <= trial;
      else rem_r <= rsh;
      // Build stripe number times chunk one quotient bit at a time.
      qc_r <= {qc_r[r0s_pkg::DOFF_W-2:0], 1'b0} +
              (trial[r0s_pkg::WID_W] ? '0 :
               {{(r0s_pkg::DOFF_W-r0s_pkg::CHUNK_W){1'b0}}, chunk});
      dvd_r <= {dvd_r[r0s_pkg::POS_W-2:0], 1'b0};
      step_r <= step_r - 1'b1;
    end
    if (cmd.div_latch) begin
      if (cmd.div_sel_end) begin
        we_r <= rem_r[r0s_pkg::WID_W-1:0];
        sbe_r <= qc_r;
      end else begin
        ws_r <= rem_r[r0s_pkg::WID_W-1:0];
        sbs_r <= qc_r;
      end
    end
    if (cmd.first_dev) begin
      dev_r <= fdev[r0s_pkg::DIDX_W-1:0];
      base_r <= r0s_pkg::WID_W'(fdev) * r0s_pkg::WID_W'(chunk);
      vis_r <= r0s_pkg::CNT_W'(1);
    end
    if (cmd.emit) begin
      o_dev <= dev_r;
      o_off <= ds;
      o_len <= dl;
      o_last <= (dl >= left_r) || (vis_r == ndev);
      left_r <= (dl >= left_r) ? '0 : left_r - dl;
    end
    if (cmd.next_dev) begin
      vis_r <= vis_r + 1'b1;
      if (r0s_pkg::CNT_W'(dev_r) + 1'b1 >= ndev) begin
        dev_r <= '0;
        base_r <= '0;
      end else begin
        dev_r <= dev_r + 1'b1;
        base_r <= base_r + r0s_pkg::WID_W'(chunk);
      end
    end
  end
endmodule

// ----- src/r0s_control.sv -----
// Controller: sequences the two divisions and the per-member output requests.
// Depends on r0s_pkg.
module r0s_control (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  r0s_pkg::r0s_sts_t sts,
  output r0s_pkg::r0s_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  typedef enum logic [2:0] {
    S_IDLE, S_DIV_OFF, S_DIV_END, S_FIRST, S_EMIT, S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   fin_r, fin_nxt;
  logic   sel_r, sel_nxt;

  assign busy = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    ovalid_nxt = ovalid_r;
    fin_nxt = fin_r;
    sel_nxt = sel_r;
    cmd = '0;
    cmd.div_sel_end = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          if (!sts.len_zero) begin
            state_nxt = S_DIV_OFF;
            sel_nxt = 1'b0;
            fin_nxt = 1'b0;
          end
        end
      end
      S_DIV_OFF, S_DIV_END: begin
        if (fin_r == 1'b0) begin
          cmd.div_start = 1'b1;
          fin_nxt = 1'b1;
        end else if (!sts.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.div_latch = 1'b1;
          fin_nxt = 1'b0;
          if (state_r == S_DIV_OFF) begin
            sel_nxt = 1'b1;
            state_nxt = S_DIV_END;
          end else begin
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        cmd.first_dev = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!ovalid_r || out_fire) begin
          cmd.emit = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_HOLD;
        end else if (out_fire) begin
          ovalid_nxt = 1'b0;
        end
      end
      S_HOLD: begin
        if (out_fire) ovalid_nxt = 1'b0;
        if (sts.left_zero || sts.at_last_visit) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.next_dev = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r != S_EMIT && state_r != S_HOLD && out_fire) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      fin_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      fin_r <= fin_nxt;
      sel_r <= sel_nxt;
    end
  end

`ifndef SYNTH
  a_no_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!ovalid_r || out_fire)) else $error("result overwritten");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> ovalid_r) else $error("emitted result not valid");
  a_idle_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(cmd.emit || cmd.div_step)) else $error("idle datapath busy");
`endif
endmodule

// ----- tb/sv/raid0_request_splitter_checker.sv -----
// Scoreboard for the RAID-0 request splitter: watches the request, sub-request and register
// ports, predicts each split and compares it field by field. Depends on r0s_pkg.
`timescale 1ns / 100ps
module raid0_request_splitter_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [87:0]                   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [95:0]                   out_tdata,
  input  logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [r0s_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r0s_pkg::CHUNK_W-1:0]   cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  typedef struct packed {
    logic [r0s_pkg::DIDX_W-1:0] idx;
    logic [r0s_pkg::DOFF_W-1:0] doff;
    logic [r0s_pkg::LEN_W-1:0]  dlen;
    logic                       last;
  } subreq_t;

  subreq_t                     expected_subreqs[$];
  logic [r0s_pkg::CNT_W-1:0]   member_count;
  logic [r0s_pkg::CHUNK_W-1:0] chunk_bytes;

  assign pending = expected_subreqs.size();

  // Member-local offset of a logical position, clamped to the member's chunk.
  function automatic longint unsigned member_offset(longint unsigned dev, longint unsigned pos,
                                                    longint unsigned ndev,
                                                    longint unsigned chunk);
    longint unsigned width;
    longint unsigned pos_in_stripe;
    longint unsigned part;
    width = ndev * chunk;
    pos_in_stripe = pos % width;
    if (pos_in_stripe < dev * chunk) part = 0;
    else begin
      part = pos_in_stripe - dev * chunk;
      if (part > chunk) part = chunk;
    end
    return (pos / width) * chunk + part;
  endfunction

  function automatic void split_request(logic [r0s_pkg::OFF_W-1:0] off,
                                        logic [r0s_pkg::LEN_W-1:0] len);
    longint unsigned ndev;
    longint unsigned chunk;
    longint unsigned end_pos;
    longint unsigned left;
    longint unsigned dev;
    longint unsigned ds;
    longint unsigned de;
    longint unsigned dl;
    subreq_t s;
    ndev = (member_count == 0) ? 1 : member_count;
    if (ndev > r0s_pkg::MAX_DEVICES) ndev = r0s_pkg::MAX_DEVICES;
    chunk = (chunk_bytes == 0) ? 1 : chunk_bytes;
    end_pos = off + len;
    left = len;
    dev = (off % (ndev * chunk)) / chunk;
    for (longint unsigned i = 0; i < ndev && left > 0; i++) begin
      ds = member_offset(dev, off, ndev, chunk);
      de = member_offset(dev, end_pos, ndev, chunk);
      dl = (de >= ds) ? de - ds : 0;
      dl = dl & 64'hFF_FFFF_FFFF;
      left = (dl >= left) ? 0 : left - dl;
      s.idx = dev[r0s_pkg::DIDX_W-1:0];
      s.doff = ds[r0s_pkg::DOFF_W-1:0];
      s.dlen = dl[r0s_pkg::LEN_W-1:0];
      s.last = (left == 0) || (i + 1 == ndev);
      expected_subreqs.insert(expected_subreqs.size(), s);
      dev = (dev + 1 >= ndev) ? 0 : dev + 1;
    end
  endfunction

  always @(posedge clk) begin
    subreq_t got;
    subreq_t want;
    if (!rst_n) begin
      member_count <= 5'd2;
      chunk_bytes <= 32'd4194304;
      fail_count <= 0;
      expected_subreqs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == r0s_pkg::REG_DEVICE_COUNT)
          member_count <= cfg_wdata[r0s_pkg::CNT_W-1:0];
        else if (cfg_index == r0s_pkg::REG_CHUNK_SIZE) chunk_bytes <= cfg_wdata;
      end
      if (in_tvalid && in_tready) split_request(in_tdata[46:0], in_tdata[86:47]);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[3:0], out_tdata[51:4], out_tdata[91:52], out_tlast};
        if (expected_subreqs.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected sub-request: dev %0d off %0h len %0h last %0b",
                     got.idx, got.doff, got.dlen, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_subreqs.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("sub-request mismatch: exp dev %0d off %0h len %0h last %0b,",
                       want.idx, want.doff, want.dlen, want.last,
                       " got dev %0d off %0h len %0h last %0b",
                       got.idx, got.doff, got.dlen, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/raid0_request_splitter_tb.sv -----
// Testbench top for the RAID-0 request splitter: clock, reset, request and register stimulus,
// verdict. Depends on r0s_pkg, raid0_request_splitter and raid0_request_splitter_checker.
`timescale 1ns / 100ps
module raid0_request_splitter_tb;
  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [87:0]                   in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  logic [95:0]                   out_tdata;
  logic                          out_tlast;
  logic                          cfg_we;
  logic [r0s_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [r0s_pkg::CHUNK_W-1:0]   cfg_wdata;
  int                            fail_count;
  int                            pending;
  bit                            quiet;
  int                            out_stall;

  raid0_request_splitter dut (.*);

  raid0_request_splitter_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[raid0_request_splitter] ERROR");
    $finish;
  end

  // Stall the result side in short random bursts.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1'b1;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      out_stall <= $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(logic [r0s_pkg::OFF_W-1:0] off, logic [r0s_pkg::LEN_W-1:0] len);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, len, off};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // Drain, let a zero-length request finish, then reprogram both registers.
  task automatic set_geometry(logic [r0s_pkg::CHUNK_W-1:0] members,
                              logic [r0s_pkg::CHUNK_W-1:0] chunk);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r0s_pkg::REG_DEVICE_COUNT;
    cfg_wdata <= members;
    @(posedge clk);
    cfg_index <= r0s_pkg::REG_CHUNK_SIZE;
    cfg_wdata <= chunk;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_requests(int n, logic [r0s_pkg::CHUNK_W-1:0] chunk, int members);
    logic [63:0] off;
    logic [63:0] len;
    longint unsigned stripe;
    stripe = longint'(members == 0 ? 1 : (members > 16 ? 16 : members)) *
             longint'(chunk == 0 ? 1 : chunk);
    for (int i = 0; i < n; i++) begin
      off = {$urandom, $urandom};
      len = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: len = len % (2 * stripe + 1);
        1: len = len % (stripe + 1);
        2: begin
          off = (off % 1024) * stripe;
          len = len % (3 * stripe + 1);
        end
        3: off = off & 64'hFFFF_FFFF;
        default: ;
      endcase
      if ($urandom_range(0, 19) == 0) len = 0;
      send_request(off[r0s_pkg::OFF_W-1:0], len[r0s_pkg::LEN_W-1:0]);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = r0s_pkg::REG_DEVICE_COUNT;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: two members, 4 MiB chunks.
    send_request(47'd0, 40'd0);
    send_request(47'd0, 40'd1);
    send_request(47'd4194303, 40'd2);
    send_request(47'd4194304, 40'd8388608);
    send_request(47'd100, 40'd20000000);
    send_request({r0s_pkg::OFF_W{1'b1}}, {r0s_pkg::LEN_W{1'b1}});
    send_request({r0s_pkg::OFF_W{1'b1}}, 40'd1);
    send_request(47'd0, {r0s_pkg::LEN_W{1'b1}});
    random_requests(20, 32'd4194304, 2);

    set_geometry(32'd1, 32'd1);
    send_request(47'd5, 40'd7);
    send_request({r0s_pkg::OFF_W{1'b1}}, {r0s_pkg::LEN_W{1'b1}});
    random_requests(15, 32'd1, 1);

    set_geometry(32'd16, 32'hFFFF_FFFF);
    send_request(47'd0, {r0s_pkg::LEN_W{1'b1}});
    send_request({r0s_pkg::OFF_W{1'b1}}, {r0s_pkg::LEN_W{1'b1}});
    send_request(47'hFFFF_FFFE, 40'd3);
    random_requests(20, 32'hFFFF_FFFF, 16);

    // Zero count and zero chunk fold to one; oversize count saturates.
    set_geometry(32'd0, 32'd0);
    send_request(47'd3, 40'd9);
    random_requests(10, 32'd0, 0);

    set_geometry(32'd31, 32'd7);
    send_request(47'd0, 40'd112);
    send_request(47'd5, 40'd200);
    random_requests(20, 32'd7, 31);

    set_geometry(32'hFFFF_FFF5, 32'd4096);
    random_requests(20, 32'd4096, 21);

    set_geometry(32'd3, 32'd1000);
    random_requests(25, 32'd1000, 3);

    set_geometry(32'd16, 32'd512);
    quiet <= 1'b1;
    random_requests(30, 32'd512, 16);

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[raid0_request_splitter] OK");
    end else begin
      $display("[raid0_request_splitter] ERROR");
    end
    $finish;
  end
endmodule
